@@ rtl/lr_pkg.sv @@
`timescale 1ns / 1ps

package lr_pkg;

   // Operation codes carried on req_op
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // Direction and shape flags worked out when a line starts
   typedef struct packed {
      logic x_backward;
      logic y_backward;
      logic steep;
      logic degenerate;
   } line_flags_type;

endpackage

@@ rtl/lr_setup.sv @@
`timescale 1ns / 1ps

module lr_setup
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]        start_x,
   input  logic [COORD_BITS-1:0]        start_y,
   input  logic [COORD_BITS-1:0]        end_x,
   input  logic [COORD_BITS-1:0]        end_y,
   output line_flags_type               flags,
   output logic signed [COORD_BITS+2:0] decision,
   output logic signed [COORD_BITS+2:0] incr_one,
   output logic signed [COORD_BITS+2:0] incr_two
);

   localparam int DW = COORD_BITS + 3;

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic signed [DW-1:0]  dx_s;
   logic signed [DW-1:0]  dy_s;
   logic signed [DW-1:0]  dx2;
   logic signed [DW-1:0]  dy2;

   always_comb begin
      dx = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
      dy = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
      dx_s = signed'({3'b000, dx});
      dy_s = signed'({3'b000, dy});
      dx2 = dx_s <<< 1;
      dy2 = dy_s <<< 1;

      // an axis with equal coordinates counts as backward; it never steps
      flags.x_backward = !(start_x < end_x);
      flags.y_backward = !(start_y < end_y);
      flags.steep      = dy > dx;
      flags.degenerate = (dx == '0) && (dy == '0);

      incr_two = dx2 - dy2;
      if (!flags.steep) begin
         decision = dx_s - dy2;
         incr_one = -dy2;
      end else begin
         decision = dx2 - dy_s;
         incr_one = dx2;
      end
   end

endmodule

@@ rtl/line_rasterizer.sv @@
`timescale 1ns / 1ps
// Bresenham line rasterizer, all octants.
// Latency: a result appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless a held result waits on rsp_ready;
// each step is one add and one compare feeding the line state and the result register.
// Reset (synchronous, active high) drops any line in progress and empties the
// result register.

module line_rasterizer
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [23:0]           req_color,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_valid_res,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [23:0]           rsp_pixel_color,
   output logic                  rsp_last
);

   localparam int DW = COORD_BITS + 3;

   // line state
   logic                  active_ff,     active_in;
   logic [COORD_BITS-1:0] cur_x_ff,      cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff,      cur_y_in;
   logic [COORD_BITS-1:0] target_x_ff,   target_x_in;
   logic [COORD_BITS-1:0] target_y_ff,   target_y_in;
   line_flags_type        flags_ff,      flags_in;
   logic signed [DW-1:0]  decision_ff,   decision_in;
   logic signed [DW-1:0]  incr_one_ff,   incr_one_in;
   logic signed [DW-1:0]  incr_two_ff,   incr_two_in;
   logic [23:0]           held_color_ff, held_color_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  valid_res_ff,  valid_res_in;
   logic [COORD_BITS-1:0] pixel_x_ff,    pixel_x_in;
   logic [COORD_BITS-1:0] pixel_y_ff,    pixel_y_in;
   logic [23:0]           pixel_color_ff, pixel_color_in;
   logic                  last_ff,       last_in;

   line_flags_type        setup_flags;
   logic signed [DW-1:0]  setup_decision;
   logic signed [DW-1:0]  setup_incr_one;
   logic signed [DW-1:0]  setup_incr_two;

   logic                  req_fire;
   logic                  minor_step;
   logic                  decision_pos;
   logic [COORD_BITS-1:0] next_x;
   logic [COORD_BITS-1:0] next_y;

   lr_setup #(
      .COORD_BITS(COORD_BITS)
   ) u_setup (
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .flags    (setup_flags),
      .decision (setup_decision),
      .incr_one (setup_incr_one),
      .incr_two (setup_incr_two)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      decision_pos = !decision_ff[DW-1] && (decision_ff != '0);
      // shallow lines step y on a non-positive term, steep lines step x on a positive one
      minor_step   = flags_ff.steep ? decision_pos : !decision_pos;
      next_x = flags_ff.x_backward ? (cur_x_ff - COORD_BITS'(1)) : (cur_x_ff + COORD_BITS'(1));
      next_y = flags_ff.y_backward ? (cur_y_ff - COORD_BITS'(1)) : (cur_y_ff + COORD_BITS'(1));

      active_in     = active_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      flags_in      = flags_ff;
      decision_in   = decision_ff;
      incr_one_in   = incr_one_ff;
      incr_two_in   = incr_two_ff;
      held_color_in = held_color_ff;

      valid_res_in   = 1'b0;
      pixel_x_in     = '0;
      pixel_y_in     = '0;
      pixel_color_in = '0;
      last_in        = 1'b0;

      if (req_op == OP_START) begin
         cur_x_in      = req_start_x;
         cur_y_in      = req_start_y;
         target_x_in   = req_end_x;
         target_y_in   = req_end_y;
         flags_in      = setup_flags;
         decision_in   = setup_decision;
         incr_one_in   = setup_incr_one;
         incr_two_in   = setup_incr_two;
         held_color_in = req_color;
         active_in     = !setup_flags.degenerate;

         valid_res_in   = 1'b1;
         pixel_x_in     = req_start_x;
         pixel_y_in     = req_start_y;
         pixel_color_in = req_color;
         last_in        = setup_flags.degenerate;
      end else if (active_ff) begin
         if (!flags_ff.steep) begin
            decision_in = decision_ff + (decision_pos ? incr_one_ff : incr_two_ff);
            cur_x_in    = next_x;
            if (minor_step) begin
               cur_y_in = next_y;
            end
            last_in = (next_x == target_x_ff);
         end else begin
            decision_in = decision_ff + (decision_pos ? incr_two_ff : incr_one_ff);
            cur_y_in    = next_y;
            if (minor_step) begin
               cur_x_in = next_x;
            end
            last_in = (next_y == target_y_ff);
         end
         active_in      = !last_in;
         valid_res_in   = 1'b1;
         pixel_x_in     = cur_x_in;
         pixel_y_in     = cur_y_in;
         pixel_color_in = held_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            active_ff    <= active_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         target_x_ff    <= target_x_in;
         target_y_ff    <= target_y_in;
         flags_ff       <= flags_in;
         decision_ff    <= decision_in;
         incr_one_ff    <= incr_one_in;
         incr_two_ff    <= incr_two_in;
         held_color_ff  <= held_color_in;
         valid_res_ff   <= valid_res_in;
         pixel_x_ff     <= pixel_x_in;
         pixel_y_ff     <= pixel_y_in;
         pixel_color_ff <= pixel_color_in;
         last_ff        <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = valid_res_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_last        = last_ff;

   // a start whose endpoints coincide gives a single final pixel
   a_degenerate_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == OP_START) && (req_start_x == req_end_x)
         && (req_start_y == req_end_y)
      |=> rsp_valid && rsp_valid_res && rsp_last && !active_ff)
      else $error("degenerate line did not end at once");

   // an advance with no line in progress yields an empty result
   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == OP_ADVANCE) && !active_ff
      |=> rsp_valid && !rsp_valid_res && !rsp_last)
      else $error("advance without a line produced a pixel");

   // the held result and the line state agree on whether the line goes on
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> (rsp_last == !active_ff))
      else $error("last flag and active line disagree");

endmodule

@@ verif/line_rasterizer_tb.sv @@
`timescale 1ns / 1ps

module line_rasterizer_tb;
   import lr_pkg::*;

   localparam int CW          = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1950;
   localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};

   typedef struct packed {
      logic          valid_res;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [23:0]   color;
      logic          last;
   } pixel_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          req_op;
   logic [CW-1:0] req_start_x;
   logic [CW-1:0] req_start_y;
   logic [CW-1:0] req_end_x;
   logic [CW-1:0] req_end_y;
   logic [23:0]   req_color;
   logic          rsp_valid;
   logic          rsp_ready;
   logic          rsp_valid_res;
   logic [CW-1:0] rsp_pixel_x;
   logic [CW-1:0] rsp_pixel_y;
   logic [23:0]   rsp_pixel_color;
   logic          rsp_last;

   line_rasterizer #(.COORD_BITS(CW)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted line state
   logic           line_active;
   logic [CW-1:0]  pos_x, pos_y, goal_x, goal_y;
   line_flags_type shape;
   int             err_term, inc_minor_hold, inc_minor_step;
   logic [23:0]    line_color;

   pixel_type pixel_queue[$];
   int     errors      = 0;
   int     items_sent  = 0;
   int     cycle_count = 0;
   bit     calm        = 1'b0;   // no idling on either side while set

   function automatic pixel_type rasterize_step(input logic op,
                                             input logic [CW-1:0] sx, sy, ex, ey,
                                             input logic [23:0] col);
      pixel_type px;
      int     dx, dy;
      px = '0;
      if (op == OP_START) begin
         dx = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
         dy = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
         pos_x            = sx;
         pos_y            = sy;
         goal_x           = ex;
         goal_y           = ey;
         line_color       = col;
         shape.x_backward = !(sx < ex);
         shape.y_backward = !(sy < ey);
         shape.steep      = dy > dx;
         shape.degenerate = (dx == 0) && (dy == 0);
         if (!shape.steep) begin
            err_term       = dx - 2 * dy;
            inc_minor_hold = -2 * dy;
            inc_minor_step = 2 * (dx - dy);
         end else begin
            err_term       = 2 * dx - dy;
            inc_minor_hold = 2 * dx;
            inc_minor_step = 2 * (dx - dy);
         end
         px.last     = shape.degenerate;
         line_active = !shape.degenerate;
      end else if (!line_active) begin
         return px;
      end else if (!shape.steep) begin
         // shallow: minor axis steps when the term is <= 0
         if (err_term > 0) begin
            err_term += inc_minor_hold;
         end else begin
            err_term += inc_minor_step;
            pos_y = shape.y_backward ? pos_y - 1'b1 : pos_y + 1'b1;
         end
         pos_x       = shape.x_backward ? pos_x - 1'b1 : pos_x + 1'b1;
         px.last     = pos_x == goal_x;
         line_active = !px.last;
      end else begin
         // steep: minor axis steps when the term is > 0
         if (err_term > 0) begin
            err_term += inc_minor_step;
            pos_x = shape.x_backward ? pos_x - 1'b1 : pos_x + 1'b1;
         end else begin
            err_term += inc_minor_hold;
         end
         pos_y       = shape.y_backward ? pos_y - 1'b1 : pos_y + 1'b1;
         px.last     = pos_y == goal_y;
         line_active = !px.last;
      end
      px.valid_res = 1'b1;
      px.x         = pos_x;
      px.y         = pos_y;
      px.color     = line_color;
      return px;
   endfunction

   task automatic send_item(input logic op, input logic [CW-1:0] sx, sy, ex, ey,
                            input logic [23:0] col);
      int        gap;
      pixel_type expected;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      req_color   <= col;
      do @(posedge clock); while (!req_ready);
      expected    = rasterize_step(op, sx, sy, ex, ey, col);
      pixel_queue = {pixel_queue, expected};
      items_sent++;
   endtask

   // Start a line, then issue advances with junk in the unused fields
   task automatic send_line(input logic [CW-1:0] sx, sy, ex, ey, input logic [23:0] col,
                            input int advances);
      send_item(OP_START, sx, sy, ex, ey, col);
      repeat (advances)
         send_item(OP_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom), 24'($urandom));
   endtask

   function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] c, input int reach);
      int d, e;
      d = $urandom_range(0, reach);
      e = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
      if (e < 0 || e > int'(COORD_MAX))
         e = 2 * int'(c) - e;
      return e[CW-1:0];
   endfunction

   task automatic test_special_cases;
      send_item(OP_ADVANCE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF, 1);
      // full-size diagonal, abandoned by the next start
      send_line('0, '0, COORD_MAX, COORD_MAX, 24'h000000, 2);
      send_line(COORD_MAX, '0, '0, COORD_MAX, 24'hA5A5A5, 1);
   endtask

   task automatic test_axis_and_ties;
      send_line(12'd10, 12'd20, 12'd13, 12'd20, 24'h123456, 3);
      send_line(12'd7, 12'd9, 12'd7, 12'd6, 24'hFEDCBA, 3);
      send_line('0, '0, 12'd4, 12'd2, 24'h5A5A5A, 4);
      send_line(COORD_MAX, '0, COORD_MAX - 12'd2, 12'd4, 24'hFFFFFF, 4);
   endtask

   task automatic test_random_lines(input int budget);
      int            base, kind, len, dx, dy, reach;
      logic [CW-1:0] sx, sy, ex, ey;
      base = items_sent;
      while (items_sent - base < budget) begin
         if ($urandom_range(0, 7) == 0)
            calm = ($urandom_range(0, 2) == 0);
         kind  = $urandom_range(0, 19);
         reach = ($urandom_range(0, 4) == 0) ? 2 : 14;
         sx = CW'($urandom_range(0, int'(COORD_MAX)));
         sy = CW'($urandom_range(0, int'(COORD_MAX)));
         if (kind < 2) begin
            ex = CW'($urandom_range(0, int'(COORD_MAX)));
            ey = CW'($urandom_range(0, int'(COORD_MAX)));
         end else begin
            ex = near_coord(sx, reach);
            ey = near_coord(sy, reach);
         end
         dx  = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
         dy  = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
         len = (dx > dy) ? dx : dy;
         if (kind < 2)
            send_line(sx, sy, ex, ey, 24'($urandom), $urandom_range(0, 8));
         else if (kind == 2)
            send_item(OP_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom),
                      CW'($urandom), 24'($urandom));
         else if (kind < 6 && len > 0)
            send_line(sx, sy, ex, ey, 24'($urandom), $urandom_range(0, len - 1));
         else if (kind < 8)
            send_line(sx, sy, ex, ey, 24'($urandom), len + $urandom_range(1, 2));
         else
            send_line(sx, sy, ex, ey, 24'($urandom), len);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            $error("result transaction with no expected pixel");
            errors++;
         end else begin
            want = pixel_queue.pop_front();
            check_field("valid_res", 32'(want.valid_res), 32'(rsp_valid_res));
            check_field("pixel_x", 32'(want.x), 32'(rsp_pixel_x));
            check_field("pixel_y", 32'(want.y), 32'(rsp_pixel_y));
            check_field("pixel_color", 32'(want.color), 32'(rsp_pixel_color));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   initial begin : drain_pixels
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      line_active = 1'b0;
      pos_x = '0; pos_y = '0; goal_x = '0; goal_y = '0;
      shape = '0;
      err_term = 0; inc_minor_hold = 0; inc_minor_step = 0;
      line_color = '0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_op      <= OP_START;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x   <= '0;
      req_end_y   <= '0;
      req_color   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_axis_and_ties();
      test_random_lines(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
